FILE: hdl/svd_pkg.sv
// Package for the saccade velocity detector: widths, window constants,
// state and register codes, and the per-eye tracking result record.
// No dependencies.
package svd_pkg;

    localparam int VelW      = 16;
    localparam int TimeW     = 32;
    localparam int SpeedW    = 16;
    localparam int LenW      = 12;
    localparam int CutW      = 16;
    localparam int Window    = 8;
    localparam int WinAw     = $clog2(Window);
    localparam int SumW      = VelW + WinAw;
    localparam int SqW       = 32;
    localparam int RootSteps = SqW / 2;
    localparam int StepW     = $clog2(RootSteps + 1);

    localparam logic [LenW-1:0] LenMax = '1;

    // Configuration register indexes.
    localparam logic [0:0] RegCutoff = 1'b0;
    localparam logic [0:0] RegMinLen = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ROOT,
        ST_TRACK,
        ST_OUT
    } t_state;

    // Outcome of one eye's tracking step.
    typedef struct packed {
        logic             done;
        logic [TimeW-1:0] onset;
        logic [LenW-1:0]  length;
    } t_report;

endpackage

FILE: hdl/saccade_velocity_detector.sv
// Saccade velocity detector top level: window store, running sums,
// squaring sequencer, two roots and two eye trackers. Depends on svd_pkg.
//
// Usage: samples enter on the s_axis channel (tdata bits, lowest first:
// right_vel_x, right_vel_y, left_vel_x, left_vel_y, sample_time). The
// first seven samples after reset only fill the window and yield nothing.
// Those filling transactions can follow each other with no gap. Every
// later sample yields one result transaction on m_axis.
// An item passes these steps from acceptance to its result being offered:
// square the x means, add the y squares into the digit-serial square
// roots, run the roots (two bits a cycle), see both roots finish, track
// and load the output register. The block accepts one item at a time
// and accepts the next only once the result has been taken. When the
// receiver stalls the result is held and no new item is accepted until it
// is taken. Reset clears the window fill, sums and trackers and sets
// cutoff 100 and minimum length 3. Configuration writes (index 0 cutoff,
// index 1 minimum length) are to be taken only while idle; the user must
// keep to this, as the block itself does not enforce it.
module saccade_velocity_detector
    import svd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // right_vel_x, right_vel_y, left_vel_x, left_vel_y, sample_time
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_time, right_speed, left_speed, right_saccade_done, right_onset,
    // right_length, left_saccade_done, left_onset, left_length, 6 pad bits
    output logic [159:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    logic [4*VelW-1:0]  r_win [Window];
    logic [WinAw-1:0]   r_slot;
    logic [WinAw:0]     r_fill;
    logic signed [SumW-1:0] r_sum [4];
    logic               r_have_prev;
    logic [CutW-1:0]    r_cutoff;
    logic [LenW-1:0]    r_min_len;
    logic [TimeW-1:0]   r_time;
    logic [SqW-1:0]     r_sq [2];
    logic               r_out_valid;
    logic [159:0]       r_out;
    t_state             r_state, n_state;

    logic signed [VelW-1:0] w_v [4];
    logic signed [VelW-1:0] w_old [4];
    logic signed [SumW-1:0] w_nsum [4];
    logic signed [VelW-1:0] w_mean [4];
    logic [SqW-1:0]     w_rad [2];
    logic               w_root_start;
    logic               w_busy_r, w_busy_l;
    logic [SpeedW-1:0]  w_speed_r, w_speed_l;
    logic               w_step;
    t_report            w_rep_r, w_rep_l;
    logic               w_accept;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;

    // New sums: add the incoming sample, drop the one it replaces.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_v[k]    = s_axis_tdata[k*VelW +: VelW];
            w_old[k]  = r_fill[WinAw] ? r_win[r_slot][k*VelW +: VelW] : '0;
            w_nsum[k] = r_sum[k] + SumW'(w_v[k]) - SumW'(w_old[k]);
            // Mean truncated toward zero: bias negatives before shifting.
            w_mean[k] = VelW'((r_sum[k] + (r_sum[k][SumW-1] ?
                        SumW'(Window - 1) : SumW'(0))) >>> WinAw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_win[r_slot] <= s_axis_tdata[4*VelW-1:0];
            r_time        <= s_axis_tdata[4*VelW +: TimeW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_fill <= '0;
            for (int k = 0; k < 4; k++) r_sum[k] <= '0;
        end else if (w_accept) begin
            r_slot <= r_slot + 1'b1;
            if (!r_fill[WinAw]) r_fill <= r_fill + 1'b1;
            for (int k = 0; k < 4; k++) r_sum[k] <= w_nsum[k];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff  <= CutW'(100);
            r_min_len <= LenW'(3);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegCutoff: r_cutoff  <= i_cfg_data;
                RegMinLen: r_min_len <= i_cfg_data[LenW-1:0];
                default: ;
            endcase
        end
    end

    // Squares: x first, registered, one x multiplier per eye.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SQ_X) begin
            r_sq[0] <= SqW'($signed(w_mean[0]) * $signed(w_mean[0]));
            r_sq[1] <= SqW'($signed(w_mean[2]) * $signed(w_mean[2]));
        end
    end

    // The y square is added on the way into the roots.
    always_comb begin
        w_rad[0] = r_sq[0] + SqW'($signed(w_mean[1]) * $signed(w_mean[1]));
        w_rad[1] = r_sq[1] + SqW'($signed(w_mean[3]) * $signed(w_mean[3]));
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state      = r_state;
        w_root_start = 1'b0;
        w_step       = 1'b0;
        unique case (r_state)
            ST_IDLE:  if (w_accept && r_fill >= (WinAw+1)'(Window - 1)) n_state = ST_SQ_X;
            ST_SQ_X:  n_state = ST_SQ_Y;
            ST_SQ_Y:  begin
                w_root_start = 1'b1;
                n_state      = ST_ROOT;
            end
            ST_ROOT:  if (!w_busy_r && !w_busy_l) n_state = ST_TRACK;
            ST_TRACK: begin
                w_step  = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    svd_isqrt u_root_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_root_start),
        .i_radicand(w_rad[0]), .o_busy(w_busy_r), .o_root(w_speed_r)
    );
    svd_isqrt u_root_l (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_root_start),
        .i_radicand(w_rad[1]), .o_busy(w_busy_l), .o_root(w_speed_l)
    );

    svd_eye u_eye_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step),
        .i_have_prev(r_have_prev), .i_speed(w_speed_r), .i_time(r_time),
        .i_cutoff(r_cutoff), .i_min_len(r_min_len), .o_report(w_rep_r)
    );
    svd_eye u_eye_l (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step),
        .i_have_prev(r_have_prev), .i_speed(w_speed_l), .i_time(r_time),
        .i_cutoff(r_cutoff), .i_min_len(r_min_len), .o_report(w_rep_l)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_have_prev <= 1'b0;
        end else begin
            if (w_step) r_have_prev <= 1'b1;
            if (r_state == ST_OUT) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT) begin
            r_out <= {6'b000000, w_rep_l.length, w_rep_l.onset, w_rep_l.done,
                      w_rep_r.length, w_rep_r.onset, w_rep_r.done,
                      w_speed_l, w_speed_r, r_time};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // Checks.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !s_axis_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_roots_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy_r == w_busy_l) else $error("roots out of step");
    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[64] |-> m_axis_tdata[108:97] > r_min_len ||
        $past(i_cfg_we)) else $error("short saccade reported");

endmodule

FILE: hdl/svd_isqrt.sv
// Digit-serial integer square root: two radicand bits enter per cycle.
// Depends on svd_pkg.
module svd_isqrt
    import svd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SqW-1:0]    i_radicand,
    output logic              o_busy,
    output logic [SpeedW-1:0] o_root
);

    logic [SqW-1:0]      r_rad;
    logic [SpeedW+1:0]   r_rem;
    logic [SpeedW-1:0]   r_root;
    logic [StepW-1:0]    r_cnt;
    logic                r_busy;
    logic [SpeedW+1:0]   n_trial;
    logic [SpeedW+1:0]   n_shift;

    // One result digit: shift in two bits, try subtracting 4q+1.
    always_comb begin
        n_shift = {r_rem[SpeedW-1:0], r_rad[SqW-1 -: 2]};
        n_trial = n_shift - {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= StepW'(RootSteps);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == StepW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[SqW-3:0], 2'b00};
            if (!n_trial[SpeedW+1]) begin
                r_rem  <= n_trial;
                r_root <= {r_root[SpeedW-2:0], 1'b1};
            end else begin
                r_rem  <= n_shift;
                r_root <= {r_root[SpeedW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

FILE: hdl/svd_eye.sv
// Per-eye saccade tracker: compares speed change with the cutoff and
// keeps the saccade flag, onset and length. Depends on svd_pkg.
module svd_eye
    import svd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_have_prev,
    input  logic [SpeedW-1:0] i_speed,
    input  logic [TimeW-1:0]  i_time,
    input  logic [CutW-1:0]   i_cutoff,
    input  logic [LenW-1:0]   i_min_len,
    output t_report           o_report
);

    logic [SpeedW-1:0] r_prev;
    logic              r_in_sac;
    logic [TimeW-1:0]  r_onset;
    logic [LenW-1:0]   r_len;
    logic [SpeedW-1:0] n_diff;
    t_report           n_rep;

    always_comb begin
        n_diff = (i_speed > r_prev) ? i_speed - r_prev : r_prev - i_speed;
        n_rep  = '0;
        if (i_have_prev && r_in_sac && n_diff < i_cutoff && r_len > i_min_len) begin
            n_rep.done   = 1'b1;
            n_rep.onset  = r_onset;
            n_rep.length = r_len;
        end
    end

    // State update once per smoothed sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_in_sac <= 1'b0;
            r_onset  <= '0;
            r_len    <= '0;
            o_report <= '0;
        end else if (i_step) begin
            r_prev   <= i_speed;
            o_report <= n_rep;
            if (i_have_prev) begin
                if (!r_in_sac) begin
                    if (n_diff > i_cutoff) begin
                        r_in_sac <= 1'b1;
                        r_onset  <= i_time;
                        r_len    <= LenW'(1);
                    end
                end else if (n_diff < i_cutoff) begin
                    r_in_sac <= 1'b0;
                    r_len    <= '0;
                end else if (r_len != LenMax) begin
                    r_len <= r_len + 1'b1;
                end
            end
        end
    end

endmodule

FILE: tb/svd_checker.sv
`timescale 1ns / 1ps
// Checker for the saccade velocity detector: watches the input, output and
// configuration channels, predicts results and compares them. Uses svd_pkg.
module svd_checker
    import svd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [159:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [LenW-1:0]   l_len;
        logic [TimeW-1:0]  l_onset;
        logic              l_done;
        logic [LenW-1:0]   r_len;
        logic [TimeW-1:0]  r_onset;
        logic              r_done;
        logic [SpeedW-1:0] l_speed;
        logic [SpeedW-1:0] r_speed;
        logic [TimeW-1:0]  t;
    } t_result;

    t_result         expected_results[$];
    logic signed [VelW-1:0] vel_window[Window][4];
    int              fill;
    int              slot;
    longint          sums[4];
    int unsigned     prev_speed[2];
    bit              have_prev;
    bit              in_sacc[2];
    logic [TimeW-1:0] onset_time[2];
    int unsigned     sacc_len[2];
    int unsigned     cutoff;
    int unsigned     min_len;

    assign o_pending = expected_results.size();

    function automatic int unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return 32'(res);
    endfunction

    function automatic int unsigned smoothed_speed(longint sx, longint sy);
        longint mx;
        longint my;
        mx = sx / Window;
        my = sy / Window;
        return int_sqrt(mx * mx + my * my);
    endfunction

    // Advances one eye's saccade tracker; a report fills done, onset and length.
    task automatic track_eye(input int e, input int unsigned spd, input logic [31:0] t,
                             output logic done, output logic [31:0] on,
                             output logic [11:0] len);
        int unsigned diff;
        diff = spd > prev_speed[e] ? spd - prev_speed[e] : prev_speed[e] - spd;
        done = 0;
        on = 0;
        len = 0;
        if (!in_sacc[e]) begin
            if (diff > cutoff) begin
                in_sacc[e] = 1;
                onset_time[e] = t;
                sacc_len[e] = 1;
            end
        end else if (diff < cutoff) begin
            in_sacc[e] = 0;
            if (sacc_len[e] > min_len) begin
                done = 1;
                on = onset_time[e];
                len = 12'(sacc_len[e]);
            end
            sacc_len[e] = 0;
        end else if (sacc_len[e] < LenMax) begin
            sacc_len[e]++;
        end
    endtask

    task automatic predict_sample(input logic [95:0] d);
        logic signed [VelW-1:0] v[4];
        t_result r;
        int unsigned rs;
        int unsigned ls;
        for (int k = 0; k < 4; k++) v[k] = d[16*k +: 16];
        for (int k = 0; k < 4; k++) begin
            if (fill >= Window) sums[k] -= vel_window[slot][k];
            vel_window[slot][k] = v[k];
            sums[k] += v[k];
        end
        slot = (slot + 1) % Window;
        if (fill < Window) fill++;
        if (fill < Window) return;
        r = '0;
        r.t = d[95:64];
        rs = smoothed_speed(sums[0], sums[1]);
        ls = smoothed_speed(sums[2], sums[3]);
        if (have_prev) begin
            track_eye(0, rs, r.t, r.r_done, r.r_onset, r.r_len);
            track_eye(1, ls, r.t, r.l_done, r.l_onset, r.l_len);
        end
        prev_speed[0] = rs;
        prev_speed[1] = ls;
        have_prev = 1;
        r.r_speed = 16'(rs);
        r.l_speed = 16'(ls);
        expected_results.insert(expected_results.size(), r);
    endtask

    // Observes all three channels at each rising edge.
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (!i_rst_n) begin
            expected_results.delete();
            fill = 0;
            slot = 0;
            sums = '{default: 0};
            prev_speed = '{0, 0};
            have_prev = 0;
            in_sacc = '{0, 0};
            onset_time = '{0, 0};
            sacc_len = '{0, 0};
            cutoff = 100;
            min_len = 3;
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == RegCutoff) cutoff = 32'(i_cfg_data);
                else if (i_cfg_index == RegMinLen) min_len = 32'(i_cfg_data[11:0]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[153:0];
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("Unexpected result transaction: %h", got);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r || m_axis_tdata[159:154] !== 6'b000000) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("Mismatch: expected %h, got %h", exp_r,
                                     m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_sample(s_axis_tdata);
        end
    end

endmodule

FILE: tb/tb_saccade_velocity_detector.sv
`timescale 1ns / 1ps
// Testbench top for the saccade velocity detector: drives samples, stalls
// and configuration writes and prints the verdict. Uses svd_pkg, svd_checker and the DUT.
module tb_saccade_velocity_detector;
    import svd_pkg::*;

    localparam int CycleLimit = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic         i_cfg_we;
    logic [0:0]   i_cfg_index;
    logic [15:0]  i_cfg_data;
    int           fail_count;
    int           pending;
    int           cycles;
    bit           long_hold;
    logic [31:0]  clock_stamp;

    saccade_velocity_detector u_dut (.*);

    svd_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_we,
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("[saccade_velocity_detector] ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int gap;
        bit hold_done;
        hold_done = 0;
        m_axis_tready = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold && !hold_done) begin
                m_axis_tready <= 0;
                repeat (300) @(posedge i_clk);
                hold_done = 1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    function automatic logic [15:0] rand_vel(input int mode);
        case (mode)
            0: return 16'($urandom());
            1: return 16'($urandom_range(0, 200) - 100);
            2: return 16'h7fff;
            default: return 16'h8000;
        endcase
    endfunction

    // Offers one sample and waits for its transaction.
    task automatic send_sample(input logic [15:0] rx, input logic [15:0] ry,
                               input logic [15:0] lx, input logic [15:0] ly,
                               input bit random_gap);
        int gap;
        gap = random_gap ? $urandom_range(0, 6) : 0;
        if (gap > 0 && $urandom_range(0, 3) != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {clock_stamp, ly, lx, ry, rx};
        clock_stamp = clock_stamp + $urandom_range(1, 40);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    // Bursts of steady motion with sudden jumps make saccades of random length.
    task automatic saccade_burst(input int count);
        logic [15:0] base_x;
        logic [15:0] base_y;
        base_x = '0;
        base_y = '0;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 7) == 0) begin
                base_x = 16'($urandom_range(0, 4000) - 2000);
                base_y = 16'($urandom_range(0, 4000) - 2000);
            end
            if ($urandom_range(0, 19) == 0)
                send_sample(rand_vel($urandom_range(0, 3)), rand_vel(0),
                            rand_vel(0), rand_vel($urandom_range(0, 3)), 1);
            else if ($urandom_range(0, 2) == 0)
                send_sample(16'(base_x * (n % 13)), base_y,
                            16'($urandom_range(0, 40) * 100), base_x, 1);
            else
                send_sample(base_x + rand_vel(1), base_y + rand_vel(1),
                            base_y + rand_vel(1), base_x + rand_vel(1), 1);
        end
    endtask

    initial begin
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        i_cfg_we = 0;
        i_cfg_index = RegCutoff;
        i_cfg_data = 0;
        long_hold = 0;
        clock_stamp = 32'hffff_ff00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes at reset settings, window fill and first speed.
        for (int n = 0; n < 10; n++)
            send_sample(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 0);
        for (int n = 0; n < 6; n++)
            send_sample(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 0);
        for (int n = 0; n < 8; n++)
            send_sample(16'h0000, 16'hffff, 16'h0001, 16'h0000, 0);
        go_idle();

        // Register extremes, with random traffic under each setting.
        write_reg(RegCutoff, 16'd0);
        write_reg(RegMinLen, 16'd0);
        saccade_burst(250);
        go_idle();
        write_reg(RegCutoff, 16'hffff);
        write_reg(RegMinLen, 16'h0fff);
        saccade_burst(150);
        go_idle();
        write_reg(RegCutoff, 16'd46341);
        write_reg(RegMinLen, 16'd4095);
        saccade_burst(100);
        go_idle();
        write_reg(RegCutoff, 16'd0);
        write_reg(RegMinLen, 16'd1);
        // Long stream of alternating jumps keeps one saccade running.
        for (int n = 0; n < 250; n++)
            send_sample((n % 2) ? 16'h7fff : 16'h8000, 16'h0000, 16'h0000,
                        (n % 2) ? 16'h8000 : 16'h0000, 0);
        go_idle();
        write_reg(RegCutoff, 16'($urandom_range(100, 1500)));
        write_reg(RegMinLen, 16'($urandom_range(0, 5)));
        long_hold = 1;
        saccade_burst(600);
        go_idle();
        write_reg(RegCutoff, 16'($urandom_range(0, 300)));
        write_reg(RegMinLen, 16'($urandom_range(0, 12)));
        saccade_burst(550);
        go_idle();

        if (fail_count == 0) begin
            $display("[saccade_velocity_detector] OK");
        end else begin
            $display("[saccade_velocity_detector] ERROR");
        end
        $finish;
    end

endmodule

FILE: saccade_velocity_detector.f
hdl/svd_pkg.sv
hdl/svd_isqrt.sv
hdl/svd_eye.sv
hdl/saccade_velocity_detector.sv
tb/svd_checker.sv
tb/tb_saccade_velocity_detector.sv
